@@ src/assert_macros.svh @@
// Assertion macros used by the top RTL file of the two-channel SPI controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define SPI2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define SPI2C_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPI2C_ASSERT(lbl, prop, msg)
`define SPI2C_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ src/spi2c_pkg.sv @@
// Types, codes and constants of the two-channel SPI controller.
`timescale 1ns / 1ps
`default_nettype none
package spi2c_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int MAX_CHANNELS = 4;
  localparam int PRESENT_W    = 2;

  typedef enum logic [2:0] {
    ACT_REG_READ  = 3'd0,
    ACT_REG_WRITE = 3'd1,
    ACT_CS_PIN    = 3'd2,
    ACT_CLK_PIN   = 3'd3,
    ACT_MOSI_PIN  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    OFF_CONTROL   = 3'd0,
    OFF_STATUS    = 3'd1,
    OFF_PIN       = 3'd2,
    OFF_PRESCALER = 3'd3,
    OFF_TXDATA    = 3'd4,
    OFF_RXDATA    = 3'd5
  } reg_off_t;

  typedef enum logic [1:0] {
    MODE_POLL = 2'd0,
    MODE_IRQ  = 2'd1,
    MODE_DMA  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_BYTE_PRESENT = 1'b0,
    CFG_BIT_PRESENT  = 1'b1
  } cfg_reg_t;

  localparam logic [6:0] CTRL_XFER_MASK = 7'h19;
  localparam logic [6:0] CTRL_RD_MATCH  = 7'h19;
  localparam logic [6:0] CTRL_WR_MATCH  = 7'h18;
  localparam logic [7:0] DUMMY_BYTE     = 8'h51;
  localparam logic [7:0] STATUS_VALUE   = 8'h01;
  localparam logic [2:0] PIN_RESET      = 3'd2;
  localparam logic [2:0] LAST_BIT       = 3'd7;

  typedef struct packed {
    action_t    action;
    logic       channel;
    reg_off_t   reg_offset;
    logic [7:0] write_data;
    logic       pin_level;
    logic [7:0] device_reply;
    logic       bit_reply;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       transfer_start;
    logic [7:0] transfer_byte;
    logic       miso_valid;
    logic       miso_level;
    logic [1:0] irq_raise;
    logic [1:0] drq_raise;
  } result_t;

  typedef struct packed {
    logic [6:0] ctrl;
    logic [2:0] pin;
    logic [7:0] presc;
    logic [7:0] tx;
    logic [7:0] rx;
    logic [2:0] cnt;
    logic       sel;
    logic       clk_lvl;
    logic       mosi;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    ctrl: 7'd0, pin: PIN_RESET, presc: 8'd0, tx: 8'd0, rx: 8'd0,
    cnt: 3'd0, sel: 1'b0, clk_lvl: 1'b0, mosi: 1'b0
  };

endpackage
`default_nettype wire

@@ src/spi2c_engine.sv @@
// Per-channel register file and shift state; works out the result of one word.
`timescale 1ns / 1ps
`default_nettype none
module spi2c_engine #(
  parameter int CHANNELS = spi2c_pkg::CHANNELS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    fire,
  input  spi2c_pkg::item_t                       item,
  input  wire  [spi2c_pkg::PRESENT_W-1:0]        byte_present,
  input  wire  [spi2c_pkg::PRESENT_W-1:0]        bit_present,
  output spi2c_pkg::result_t                     result
);

  spi2c_pkg::chan_state_t chan_r   [CHANNELS];
  spi2c_pkg::chan_state_t chan_nxt [CHANNELS];

  always_comb begin
    spi2c_pkg::chan_state_t       cur;
    spi2c_pkg::chan_state_t       upd;
    spi2c_pkg::result_t           res;
    logic                         ch_ok;
    logic                         has_byte;
    logic                         has_bit;
    logic                         pulse;
    logic [3:0]                   sh;
    logic [7:0]                   flushed;
    logic [7:0]                   tx_new;
    logic [spi2c_pkg::MAX_CHANNELS-1:0] irq_all;
    logic [spi2c_pkg::MAX_CHANNELS-1:0] drq_all;

    ch_ok    = int'(item.channel) < CHANNELS;
    cur      = spi2c_pkg::CHAN_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c == int'(item.channel)) begin
        cur = chan_r[c];
      end
    end
    has_byte = byte_present[item.channel];
    has_bit  = bit_present[item.channel];
    res      = '0;
    upd      = cur;
    pulse    = 1'b0;
    sh       = 4'd8 - {1'b0, cur.cnt};
    flushed  = cur.tx << sh;
    tx_new   = {cur.tx[6:0], cur.mosi};

    case (item.action)
      spi2c_pkg::ACT_REG_READ: begin
        case (item.reg_offset)
          spi2c_pkg::OFF_CONTROL:   res.read_data = {1'b0, cur.ctrl};
          spi2c_pkg::OFF_STATUS:    res.read_data = spi2c_pkg::STATUS_VALUE;
          spi2c_pkg::OFF_PIN:       res.read_data = {5'd0, cur.pin};
          spi2c_pkg::OFF_PRESCALER: res.read_data = cur.presc;
          spi2c_pkg::OFF_TXDATA:    res.read_data = cur.tx;
          spi2c_pkg::OFF_RXDATA: begin
            // a read in receive mode clocks the dummy byte out to fetch the next one
            if (has_byte &&
                (cur.ctrl & spi2c_pkg::CTRL_XFER_MASK) == spi2c_pkg::CTRL_RD_MATCH) begin
              res.transfer_start = 1'b1;
              res.transfer_byte  = spi2c_pkg::DUMMY_BYTE;
              upd.rx             = item.device_reply;
            end
            pulse         = 1'b1;
            res.read_data = upd.rx;
          end
          default: res.read_data = 8'd0;
        endcase
      end
      spi2c_pkg::ACT_REG_WRITE: begin
        case (item.reg_offset)
          spi2c_pkg::OFF_CONTROL: begin
            upd.ctrl = item.write_data[6:0];
            pulse    = 1'b1;
          end
          spi2c_pkg::OFF_PIN:       upd.pin   = item.write_data[2:0];
          spi2c_pkg::OFF_PRESCALER: upd.presc = item.write_data;
          spi2c_pkg::OFF_TXDATA: begin
            upd.tx = item.write_data;
            if (has_byte &&
                (cur.ctrl & spi2c_pkg::CTRL_XFER_MASK) == spi2c_pkg::CTRL_WR_MATCH) begin
              res.transfer_start = 1'b1;
              res.transfer_byte  = item.write_data;
              upd.rx             = item.device_reply;
            end
            pulse = 1'b1;
          end
          default: upd = cur;
        endcase
      end
      spi2c_pkg::ACT_CS_PIN: begin
        if (cur.sel || item.pin_level) begin
          // flush a partial byte, left-aligned; the bit count stays
          if (cur.cnt != 3'd0 && has_byte && !has_bit) begin
            upd.tx             = flushed;
            res.transfer_start = 1'b1;
            res.transfer_byte  = flushed;
            upd.rx             = item.device_reply;
          end
        end else begin
          upd.cnt = 3'd0;
        end
        upd.sel = ~item.pin_level;
      end
      spi2c_pkg::ACT_CLK_PIN: begin
        if (cur.sel && !cur.clk_lvl && item.pin_level) begin
          res.miso_valid = 1'b1;
          if (has_bit) begin
            res.miso_level = item.bit_reply;
          end else begin
            upd.tx         = tx_new;
            res.miso_level = cur.rx[7];
            upd.rx         = {cur.rx[6:0], 1'b0};
            upd.cnt        = cur.cnt + 3'd1;
            if (cur.cnt == spi2c_pkg::LAST_BIT) begin
              if (has_byte) begin
                res.transfer_start = 1'b1;
                res.transfer_byte  = tx_new;
                upd.rx             = item.device_reply;
              end
              upd.cnt = 3'd0;
            end
          end
        end
        upd.clk_lvl = item.pin_level;
      end
      spi2c_pkg::ACT_MOSI_PIN: upd.mosi = item.pin_level;
      default: upd = cur;
    endcase

    for (int c = 0; c < CHANNELS; c++) begin
      chan_nxt[c] = chan_r[c];
      if (fire && ch_ok && c == int'(item.channel)) begin
        chan_nxt[c] = upd;
      end
    end

    // pulses reflect every channel's mode after this word's update
    irq_all = '0;
    drq_all = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (ch_ok && c == int'(item.channel)) begin
        if (upd.ctrl[6:5] == spi2c_pkg::MODE_IRQ) irq_all[c] = 1'b1;
        else if (upd.ctrl[6:5] == spi2c_pkg::MODE_DMA) drq_all[c] = 1'b1;
      end else begin
        if (chan_r[c].ctrl[6:5] == spi2c_pkg::MODE_IRQ) irq_all[c] = 1'b1;
        else if (chan_r[c].ctrl[6:5] == spi2c_pkg::MODE_DMA) drq_all[c] = 1'b1;
      end
    end
    if (pulse) begin
      res.irq_raise = irq_all[1:0];
      res.drq_raise = drq_all[1:0];
    end
    if (!ch_ok) begin
      res = '0;
    end
    result = res;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (!rst_n) begin
        chan_r[c] <= spi2c_pkg::CHAN_RESET;
      end else begin
        chan_r[c] <= chan_nxt[c];
      end
    end
  end

endmodule
`default_nettype wire

@@ src/spi_controller_two_channel_unit.sv @@
// Two-channel SPI controller: bus register access and pin-event shifting.
//
// Input channel (in_*): one word per bus access or pin event. in_tuser holds
// the action, in_tdata the channel, register offset, write byte, pin level and
// the byte and bit answers of the attached devices.
// Result channel (out_*): exactly one word per input word, carrying the read
// value, the byte handed to the byte device, the MISO drive and the
// per-channel interrupt and DMA request pulses.
// Configuration (cfg_*): APB port with two registers, byte_device_present at
// 0x0 and bit_device_present at 0x4; write them only while the block is idle.
// Path: a word accepted is registered in the input stage, worked out by the engine
// and registered in the result register before it shows on out_*. Throughput: one
// word per cycle while out_tready is high, set by the register update of the channel state.
// Reset: all channel registers go to their reset values (pin register 2),
// both presence masks clear, and both pipeline stages empty.
// Stall: the result register holds while out_tready is low; the input stage
// still takes one more word, then in_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spi_controller_two_channel_unit #(
  parameter int CHANNELS = spi2c_pkg::CHANNELS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [0] channel, [3:1] reg_offset, [11:4] write_data, [12] pin_level,
  // [20:13] device_reply, [21] bit_reply, [23:22] zero
  input  wire  [23:0] in_tdata,
  // [2:0] action
  input  wire  [2:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [7:0] read_data, [8] transfer_start, [16:9] transfer_byte, [17] miso_valid,
  // [18] miso_level, [20:19] irq_raise, [22:21] drq_raise, [23] zero
  output logic [23:0] out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                                  item_valid_r;
  spi2c_pkg::item_t                      item_r;
  logic                                  out_valid_r;
  spi2c_pkg::result_t                    out_data_r;
  spi2c_pkg::result_t                    result;
  logic [spi2c_pkg::PRESENT_W-1:0]       byte_present_r;
  logic [spi2c_pkg::PRESENT_W-1:0]       bit_present_r;
  logic                                  fire;
  logic                                  cfg_wr;
  spi2c_pkg::cfg_reg_t                   cfg_sel;

  assign fire       = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !item_valid_r || fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.drq_raise, out_data_r.irq_raise,
                       out_data_r.miso_level, out_data_r.miso_valid,
                       out_data_r.transfer_byte, out_data_r.transfer_start,
                       out_data_r.read_data};

  assign cfg_pready = 1'b1;
  assign cfg_sel    = spi2c_pkg::cfg_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_sel)
      spi2c_pkg::CFG_BYTE_PRESENT: cfg_prdata = {30'd0, byte_present_r};
      spi2c_pkg::CFG_BIT_PRESENT:  cfg_prdata = {30'd0, bit_present_r};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_present_r <= '0;
      bit_present_r  <= '0;
    end else if (cfg_wr) begin
      if (cfg_sel == spi2c_pkg::CFG_BYTE_PRESENT) byte_present_r <= cfg_pwdata[1:0];
      else bit_present_r <= cfg_pwdata[1:0];
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      item_r.action       <= spi2c_pkg::action_t'(in_tuser);
      item_r.channel      <= in_tdata[0];
      item_r.reg_offset   <= spi2c_pkg::reg_off_t'(in_tdata[3:1]);
      item_r.write_data   <= in_tdata[11:4];
      item_r.pin_level    <= in_tdata[12];
      item_r.device_reply <= in_tdata[20:13];
      item_r.bit_reply    <= in_tdata[21];
    end
  end

  spi2c_engine #(
    .CHANNELS(CHANNELS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (item_r),
    .byte_present(byte_present_r),
    .bit_present (bit_present_r),
    .result      (result)
  );

  // result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  `SPI2C_ASSERT(a_ready_low_only_when_full,
    !in_tready |-> (item_valid_r && out_valid_r && !out_tready),
    "input refused while a stage is free")
  `SPI2C_ASSERT(a_result_from_fire, $rose(out_valid_r) |-> $past(fire),
    "result appeared without a processed word")
  `SPI2C_ASSERT(a_irq_drq_exclusive,
    out_valid_r |-> ((out_data_r.irq_raise & out_data_r.drq_raise) == 2'b00),
    "interrupt and DMA pulse on the same channel")
  `SPI2C_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!out_valid_r && !item_valid_r),
    "pipeline not empty after reset")

endmodule
`default_nettype wire
